// ===== rtl/kmeg_pkg.sv =====
// ----------------------------------------------------------------------------
// kmeg_pkg
// Shared types, codes and constants of the key matrix event generator.
// ----------------------------------------------------------------------------
package kmeg_pkg;

	localparam int KMEG_ROWS  = 6;
	localparam int KMEG_COLS  = 8;

	localparam int MASK_W     = 48;   // width of the key masks
	localparam int MAP_KEYS   = 64;   // positions addressed by {row, col}
	localparam int KEY_AW     = 6;
	localparam int POS_W      = 3;    // row or column field
	localparam int TIME_W     = 32;
	localparam int MS_W       = 16;
	localparam int APB_AW     = 6;
	localparam int APB_DW     = 64;

	// floor(x/11) for x < 2^20: (x * RECIP) >> RECIP_SH is short by at most one
	localparam int  RECIP_SH  = 24;
	localparam int  RECIP     = (1 << RECIP_SH) / 11;
	localparam int  RECIP10_W = 24;
	localparam logic [RECIP10_W-1:0] RECIP10 = RECIP10_W'(RECIP * 10);
	localparam int  PROD_W    = MS_W + RECIP10_W;
	localparam int  X10_W     = 20;

	typedef enum logic [2:0] {
		REG_PRESENT = 3'd0,
		REG_REPEAT  = 3'd1,
		REG_HOLD    = 3'd2,
		REG_LONG    = 3'd3,
		REG_FIRST   = 3'd4,
		REG_MIN     = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_PRESS   = 2'd0,
		ACT_REPEAT  = 2'd1,
		ACT_LONG    = 2'd2,
		ACT_RELEASE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [MASK_W-1:0] key_present_mask;
		logic [MASK_W-1:0] repeat_key_mask;
		logic [MS_W-1:0]   hold_ms;
		logic [MS_W-1:0]   long_ms;
		logic [MS_W-1:0]   first_pause_ms;
		logic [MS_W-1:0]   min_pause_ms;
	} cfg_t;

	typedef struct packed {
		logic ready;   // scan channel may take an item
		logic start;   // item taken this cycle
		logic issue;   // send the next key into evaluation
		logic flush;   // emit the held-back event as the last one
	} cmd_t;

	typedef struct packed {
		logic stall;       // evaluated key has an event with nowhere to go
		logic last_key;    // key counter sits on the final position
		logic pend_valid;  // an event is held back
		logic out_free;    // output register can load this cycle
	} status_t;

endpackage

// ===== rtl/kmeg_scan_if.sv =====
// ----------------------------------------------------------------------------
// kmeg_scan_if
// Scan tick channel: time stamp and pressed bits of the matrix.
// ----------------------------------------------------------------------------
interface kmeg_scan_if
	import kmeg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] time_ms;
	logic [MASK_W-1:0] pressed_mask;

	modport source (output valid, output time_ms, output pressed_mask, input ready);
	modport sink   (input valid, input time_ms, input pressed_mask, output ready);
endinterface

// ===== rtl/kmeg_evt_if.sv =====
// ----------------------------------------------------------------------------
// kmeg_evt_if
// Key event channel: position, action and end-of-scan flag.
// ----------------------------------------------------------------------------
interface kmeg_evt_if
	import kmeg_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] key_row;
	logic [POS_W-1:0] key_col;
	logic [1:0]       action;
	logic             last;

	modport source (output valid, output key_row, output key_col, output action,
		output last, input ready);
	modport sink   (input valid, input key_row, input key_col, input action,
		input last, output ready);
endinterface

// ===== rtl/kmeg_regs.sv =====
// ----------------------------------------------------------------------------
// kmeg_regs
// APB register file holding the scanner configuration.
// ----------------------------------------------------------------------------
module kmeg_regs
	import kmeg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:3];
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_present_mask <= '0;
			cfg_q.repeat_key_mask  <= '0;
			cfg_q.hold_ms          <= MS_W'(100);
			cfg_q.long_ms          <= MS_W'(500);
			cfg_q.first_pause_ms   <= MS_W'(100);
			cfg_q.min_pause_ms     <= MS_W'(10);
		end else if (wr) begin
			unique case (idx)
				REG_PRESENT: cfg_q.key_present_mask <= pwdata[MASK_W-1:0];
				REG_REPEAT:  cfg_q.repeat_key_mask  <= pwdata[MASK_W-1:0];
				REG_HOLD:    cfg_q.hold_ms          <= pwdata[MS_W-1:0];
				REG_LONG:    cfg_q.long_ms          <= pwdata[MS_W-1:0];
				REG_FIRST:   cfg_q.first_pause_ms   <= pwdata[MS_W-1:0];
				REG_MIN:     cfg_q.min_pause_ms     <= pwdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PRESENT: prdata = APB_DW'(cfg_q.key_present_mask);
			REG_REPEAT:  prdata = APB_DW'(cfg_q.repeat_key_mask);
			REG_HOLD:    prdata = APB_DW'(cfg_q.hold_ms);
			REG_LONG:    prdata = APB_DW'(cfg_q.long_ms);
			REG_FIRST:   prdata = APB_DW'(cfg_q.first_pause_ms);
			REG_MIN:     prdata = APB_DW'(cfg_q.min_pause_ms);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/kmeg_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmeg_ctrl
// Scan sequencer: takes a tick, walks the keys, flushes the final event.
// ----------------------------------------------------------------------------
module kmeg_ctrl
	import kmeg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    scan_valid,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (scan_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.stall && sts.last_key) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.stall) state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				cmd.start = scan_valid;
			end
			ST_SCAN:  cmd.issue = 1'b1;
			ST_DRAIN: ;
			ST_FLUSH: cmd.flush = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== rtl/kmeg_dp.sv =====
// ----------------------------------------------------------------------------
// kmeg_dp
// Key state, press time memory, repeat timer and event output registers.
// ----------------------------------------------------------------------------
module kmeg_dp
	import kmeg_pkg::*;
#(
	parameter int ROWS = KMEG_ROWS,
	parameter int COLS = KMEG_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	input  logic [TIME_W-1:0] time_ms,
	input  logic [MASK_W-1:0] pressed_mask,
	output status_t           sts,
	kmeg_evt_if.source        evt
);

	localparam logic [POS_W-1:0] ROW_LAST = POS_W'(ROWS - 1);
	localparam logic [POS_W-1:0] COL_LAST = POS_W'(COLS - 1);

	// scan tick
	logic [TIME_W-1:0]   now_q;
	logic [MAP_KEYS-1:0] down_q;

	// key walk
	logic [POS_W-1:0] row_q, col_q;
	logic             valid_s1;
	logic [POS_W-1:0] row_s1, col_s1;
	logic [TIME_W-1:0] pt_s1;

	// per-key state
	logic [TIME_W-1:0]   press_mem [MAP_KEYS];
	logic [MAP_KEYS-1:0] held_q, ls_q;

	// repeat timer
	logic [TIME_W-1:0] lrt_q;
	logic              armed_q;
	logic [MS_W-1:0]   pause_q;
	logic [X10_W-1:0]  np_x_q;
	logic [PROD_W-1:0] np_prod_q;
	logic [MS_W-1:0]   np_q;

	// events
	logic             pend_valid_q;
	logic [POS_W-1:0] pend_row_q, pend_col_q;
	action_t          pend_act_q;
	logic             out_valid_q;
	logic [POS_W-1:0] out_row_q, out_col_q;
	action_t          out_act_q;
	logic             out_last_q;

	logic [KEY_AW-1:0] kbit, rd_addr;
	logic [MAP_KEYS-1:0] present_ext, repeat_ext;
	logic present, down, held, ls, rep;
	logic [TIME_W-1:0] age, rdiff;
	logic ev, set_held, clr_held, set_ls, clr_ls, arm, disarm, fire;
	action_t act;
	logic stall, commit, out_free, last_key, advance;
	logic load_mv, load_fl;
	logic [MS_W-1:0]   q0, q1, np_nxt;
	logic [X10_W-1:0]  rem;

	assign kbit        = {row_s1, col_s1};
	assign present_ext = MAP_KEYS'(cfg.key_present_mask);
	assign repeat_ext  = MAP_KEYS'(cfg.repeat_key_mask);
	assign present     = present_ext[kbit];
	assign rep         = repeat_ext[kbit];
	assign down        = down_q[kbit];
	assign held        = held_q[kbit];
	assign ls          = ls_q[kbit];
	assign age         = now_q - pt_s1;
	assign rdiff       = now_q - lrt_q;

	always_comb begin
		ev       = 1'b0;
		act      = ACT_PRESS;
		set_held = 1'b0;
		clr_held = 1'b0;
		set_ls   = 1'b0;
		clr_ls   = 1'b0;
		arm      = 1'b0;
		disarm   = 1'b0;
		fire     = 1'b0;
		if (valid_s1 && present) begin
			if (held) begin
				if (age > TIME_W'(cfg.hold_ms)) begin
					if (!down) begin
						clr_held = 1'b1;
						clr_ls   = 1'b1;
						disarm   = 1'b1;
						if (!ls) begin
							ev  = 1'b1;
							act = ACT_RELEASE;
						end
					end else if (rep && !ls) begin
						// arming stamps now, so it can never fire in the same visit
						if (!armed_q) begin
							arm = 1'b1;
						end else if (rdiff > TIME_W'(pause_q)) begin
							fire = 1'b1;
							ev   = 1'b1;
							act  = ACT_REPEAT;
						end
					end else if (age > TIME_W'(cfg.long_ms) && !ls) begin
						set_ls = 1'b1;
						ev     = 1'b1;
						act    = ACT_LONG;
					end
				end
			end else if (down && !ls) begin
				set_held = 1'b1;
				disarm   = 1'b1;
				ev       = 1'b1;
				act      = ACT_PRESS;
			end
		end
	end

	assign out_free = !out_valid_q || evt.ready;
	assign stall    = ev && pend_valid_q && !out_free;
	assign commit   = !stall;
	assign last_key = (row_q == ROW_LAST) && (col_q == COL_LAST);
	assign advance  = cmd.issue && !stall;
	assign load_mv  = commit && ev && pend_valid_q;
	assign load_fl  = cmd.flush && pend_valid_q && out_free;
	assign rd_addr  = stall ? kbit : {row_q, col_q};

	assign sts.stall      = stall;
	assign sts.last_key   = last_key;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

	// tick capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			now_q  <= time_ms;
			down_q <= MAP_KEYS'(pressed_mask);
		end
	end

	// key counter and evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			row_s1   <= '0;
			col_s1   <= '0;
		end else begin
			if (cmd.start) begin
				row_q <= '0;
				col_q <= '0;
			end else if (advance) begin
				if (row_q == ROW_LAST) begin
					row_q <= '0;
					col_q <= col_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			if (!stall) begin
				valid_s1 <= cmd.issue;
				row_s1   <= row_q;
				col_s1   <= col_q;
			end
		end
	end

	// press time memory: write on press, registered read of the next key
	always_ff @(posedge clk) begin
		if (commit && set_held) press_mem[kbit] <= now_q;
		pt_s1 <= press_mem[rd_addr];
	end

	// key flags and repeat timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			ls_q    <= '0;
			armed_q <= 1'b0;
			lrt_q   <= '0;
			pause_q <= '0;
		end else if (commit) begin
			if (set_held) held_q[kbit] <= 1'b1;
			if (clr_held) held_q[kbit] <= 1'b0;
			if (set_ls)   ls_q[kbit]   <= 1'b1;
			if (clr_ls)   ls_q[kbit]   <= 1'b0;
			if (disarm) armed_q <= 1'b0;
			if (arm) begin
				armed_q <= 1'b1;
				lrt_q   <= now_q;
				pause_q <= cfg.first_pause_ms;
			end
			if (fire) begin
				lrt_q   <= now_q;
				pause_q <= np_q;
			end
		end
	end

	// next interval max(floor(pause*10/11), min), two stages behind pause_q;
	// pause_q is read again no sooner than the next tick
	always_comb begin
		q0     = np_prod_q[PROD_W-1:RECIP_SH];
		rem    = np_x_q - ((X10_W'(q0) << 3) + (X10_W'(q0) << 1) + X10_W'(q0));
		q1     = (rem >= X10_W'(11)) ? q0 + 1'b1 : q0;
		np_nxt = (q1 < cfg.min_pause_ms) ? cfg.min_pause_ms : q1;
	end

	always_ff @(posedge clk) begin
		np_x_q    <= (X10_W'(pause_q) << 3) + (X10_W'(pause_q) << 1);
		np_prod_q <= PROD_W'(pause_q) * PROD_W'(RECIP10);
		np_q      <= np_nxt;
	end

	// one event held back so the final one of a tick can be flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (commit && ev)  pend_valid_q <= 1'b1;
			else if (load_fl)  pend_valid_q <= 1'b0;
			if (load_mv || load_fl) out_valid_q <= 1'b1;
			else if (evt.ready)     out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && ev) begin
			pend_row_q <= row_s1;
			pend_col_q <= col_s1;
			pend_act_q <= act;
		end
		if (load_mv || load_fl) begin
			out_row_q  <= pend_row_q;
			out_col_q  <= pend_col_q;
			out_act_q  <= pend_act_q;
			out_last_q <= load_fl;
		end
	end

	assign evt.valid   = out_valid_q;
	assign evt.key_row = out_row_q;
	assign evt.key_col = out_col_q;
	assign evt.action  = out_act_q;
	assign evt.last    = out_last_q;

endmodule

// ===== rtl/key_matrix_event_generator.sv =====
// ----------------------------------------------------------------------------
// key_matrix_event_generator
// Keypad matrix scanner with press, auto-repeat, long and release events.
// ----------------------------------------------------------------------------
// Each scan item (time_ms, pressed_mask) is walked one matrix position per
// cycle unless stalled, column outer and row inner, through ROWS*COLS
// positions; absent keys are visited but give nothing. An item is accepted,
// its positions pass through the press time memory read stage, then the walk
// drains and the last event is flagged; the walk stalls while the event
// output is blocked and a second event waits. The press time memory, with
// its one read port, and the one shared repeat timer set this one-key-a-cycle
// pace. Events are held back by one so the final event of a scan carries
// last=1; a scan with no events gives no item. Configuration registers sit
// on an APB port at byte address 8*index, 64-bit data; the user must write
// them only while no scan is in progress; the block does not enforce this.
// No clearing pass after reset is needed: only held keys use their press time.
// ----------------------------------------------------------------------------
module key_matrix_event_generator
	import kmeg_pkg::*;
#(
	parameter int ROWS = KMEG_ROWS,
	parameter int COLS = KMEG_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// channels
	kmeg_scan_if.sink         scan,
	kmeg_evt_if.source        evt
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t sts;

	kmeg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: idle until a tick, walk keys, flush the held-back event
	kmeg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	assign scan.ready = cmd.ready;

	kmeg_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.time_ms      (scan.time_ms),
		.pressed_mask (scan.pressed_mask),
		.sts          (sts),
		.evt          (evt)
	);

endmodule

// ===== tb/key_matrix_event_generator_tb.sv =====
// ----------------------------------------------------------------------------
// key_matrix_event_generator_tb
// Self-checking bench for the keypad matrix scanner with auto-repeat.
// ----------------------------------------------------------------------------
// Scan items go in through the scan channel and key events are collected on
// the event channel. Each accepted scan is run through a software copy of
// the key state, and the events it should cause are queued in visiting
// order. Every event that comes out is checked against the head of that
// queue, field by field. The run has two parts. A directed part starts
// with reset timing, then zero and full-scale timing, and crosses the 2^32
// time wrap. A random part follows with random configurations and evolving
// key masks. The APB registers are read back after each reconfiguration.
// ----------------------------------------------------------------------------
module key_matrix_event_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kmeg_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	// one scan walks every matrix position, plus accept, drain and last flag
	localparam int SETTLE_CYCLES = 2 * (KMEG_ROWS * KMEG_COLS + 3) + 20;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		action_t          action;
		logic             last;
	} key_event_t;

	// receiver behavior on the event channel
	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_PERIODIC,
		SINK_BLOCKED
	} sink_mode_t;

	// ------------------------------------------------------------------------
	// Key state tracker: mirrors the matrix state and holds the events still
	// owed by the block, oldest first.
	// ------------------------------------------------------------------------
	class key_event_tracker;
		logic [MASK_W-1:0] present_keys;
		logic [MASK_W-1:0] repeat_keys;
		logic [MS_W-1:0]   hold_ms;
		logic [MS_W-1:0]   long_ms;
		logic [MS_W-1:0]   first_pause;
		logic [MS_W-1:0]   min_pause;

		logic [TIME_W-1:0] pressed_at [MASK_W];
		bit                is_held    [MASK_W];
		bit                long_done  [MASK_W];
		logic [TIME_W-1:0] repeat_stamp;
		bit                repeat_live;
		logic [MS_W-1:0]   repeat_gap;

		key_event_t        due_events [$];
		int                mismatches;
		int                scans;
		int                events;
		int                per_action [4];

		function new();
			present_keys = '0;
			repeat_keys  = '0;
			hold_ms      = 16'd100;
			long_ms      = 16'd500;
			first_pause  = 16'd100;
			min_pause    = 16'd10;
			foreach (pressed_at[k]) begin
				pressed_at[k] = '0;
				is_held[k]    = 1'b0;
				long_done[k]  = 1'b0;
			end
			repeat_stamp = '0;
			repeat_live  = 1'b0;
			repeat_gap   = '0;
			mismatches   = 0;
			scans        = 0;
			events       = 0;
			foreach (per_action[i])
				per_action[i] = 0;
		endfunction

		function void set_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
			if (addr[2:0] == 3'b000) begin
				case (addr[5:3])
					REG_PRESENT: present_keys = data[MASK_W-1:0];
					REG_REPEAT:  repeat_keys  = data[MASK_W-1:0];
					REG_HOLD:    hold_ms      = data[MS_W-1:0];
					REG_LONG:    long_ms      = data[MS_W-1:0];
					REG_FIRST:   first_pause  = data[MS_W-1:0];
					REG_MIN:     min_pause    = data[MS_W-1:0];
					default: ;
				endcase
			end
		endfunction

		// repeat interval shrinks by 10/11, floored at the minimum
		function logic [MS_W-1:0] shrink_pause(input logic [MS_W-1:0] p);
			logic [TIME_W-1:0] q;
			q = p;
			q = (q * 10) / 11;
			if (q < min_pause)
				q = min_pause;
			return q[MS_W-1:0];
		endfunction

		function void note_scan(input logic [TIME_W-1:0] now, input logic [MASK_W-1:0] down_keys);
			key_event_t        found [$];
			key_event_t        ev;
			logic [TIME_W-1:0] age;
			logic [TIME_W-1:0] since;
			int                k;
			bit                fire;
			action_t           act;
			scans++;
			for (int c = 0; c < KMEG_COLS; c++) begin
				for (int r = 0; r < KMEG_ROWS; r++) begin
					k = r * 8 + c;
					if (k >= MASK_W)
						continue;
					if (!present_keys[k])
						continue;
					fire = 1'b0;
					act  = ACT_PRESS;
					if (is_held[k]) begin
						age = now - pressed_at[k];
						if (age > hold_ms) begin
							if (!down_keys[k]) begin
								is_held[k]   = 1'b0;
								fire         = !long_done[k];
								act          = ACT_RELEASE;
								long_done[k] = 1'b0;
								repeat_live  = 1'b0;
							end else if (repeat_keys[k] && !long_done[k]) begin
								if (!repeat_live) begin
									repeat_live  = 1'b1;
									repeat_stamp = now;
									repeat_gap   = first_pause;
								end
								since = now - repeat_stamp;
								if (since > repeat_gap) begin
									repeat_gap   = shrink_pause(repeat_gap);
									repeat_stamp = now;
									fire         = 1'b1;
									act          = ACT_REPEAT;
								end
							end else if (age > long_ms && !long_done[k]) begin
								long_done[k] = 1'b1;
								fire         = 1'b1;
								act          = ACT_LONG;
							end
						end
					end else if (down_keys[k] && !long_done[k]) begin
						is_held[k]    = 1'b1;
						pressed_at[k] = now;
						repeat_live   = 1'b0;
						fire          = 1'b1;
						act           = ACT_PRESS;
					end
					if (fire) begin
						ev.row    = 3'(r);
						ev.col    = 3'(c);
						ev.action = act;
						ev.last   = 1'b0;
						found.push_back(ev);
					end
				end
			end
			if (found.size() > 0)
				found[found.size() - 1].last = 1'b1;
			foreach (found[i])
				due_events.push_back(found[i]);
		endfunction

		function void check_event(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
				input logic [1:0] action, input logic last);
			key_event_t want;
			if (due_events.size() == 0) begin
				$error("unexpected event: row %0d col %0d action %0d last %0d",
					row, col, action, last);
				mismatches++;
				return;
			end
			want = due_events.pop_front();
			events++;
			per_action[want.action]++;
			if (row !== want.row) begin
				$error("key_row mismatch: expected %0d, actual %0d", want.row, row);
				mismatches++;
			end
			if (col !== want.col) begin
				$error("key_col mismatch: expected %0d, actual %0d", want.col, col);
				mismatches++;
			end
			if (action !== want.action) begin
				$error("action mismatch: expected %s, actual %0d", want.action.name(), action);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last mismatch: expected %0d, actual %0d", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, APB port and channels
	// ------------------------------------------------------------------------
	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	kmeg_scan_if scan_ch ();
	kmeg_evt_if  evt_ch ();

	key_event_tracker board;

	int         burst_left  = 0;    // scan items left in the current burst
	int         ready_left  = 0;    // cycles left in the current receiver mode
	sink_mode_t ready_mode  = SINK_OPEN;
	int         cycle_count = 0;

	key_matrix_event_generator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.scan    (scan_ch),
		.evt     (evt_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: switches at random between open, coin-flip, periodic and fully
	// blocked stretches so back-pressure lands on every part of a scan.
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = sink_mode_t'($urandom_range(0, 3));
			ready_left = (ready_mode == SINK_BLOCKED) ? $urandom_range(1, 12)
				: $urandom_range(8, 60);
		end
		ready_left = ready_left - 1;
		case (ready_mode)
			SINK_OPEN:     evt_ch.ready = 1'b1;
			SINK_COIN:     evt_ch.ready = 1'($urandom_range(0, 1));
			SINK_PERIODIC: evt_ch.ready = (ready_left % 4) != 0;
			default:       evt_ch.ready = 1'b0;
		endcase
	end

	// Event monitor: every accepted event goes to the tracker.
	always @(posedge clk) begin
		if (arst_n && evt_ch.valid && evt_ch.ready)
			board.check_event(evt_ch.key_row, evt_ch.key_col, evt_ch.action, evt_ch.last);
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	function automatic logic [MASK_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[MASK_W-1:0];
	endfunction

	// mostly a range, now and then full scale
	function automatic logic [MS_W-1:0] pick_ms(input int lo, input int hi);
		if ($urandom_range(0, 7) == 0)
			return '1;
		return MS_W'($urandom_range(lo, hi));
	endfunction

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(addr, data);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_timing(input logic [MS_W-1:0] hold_v, input logic [MS_W-1:0] long_v,
			input logic [MS_W-1:0] first_v, input logic [MS_W-1:0] min_v);
		apb_write({REG_HOLD, 3'b000}, 64'(hold_v));
		apb_write({REG_LONG, 3'b000}, 64'(long_v));
		apb_write({REG_FIRST, 3'b000}, 64'(first_v));
		apb_write({REG_MIN, 3'b000}, 64'(min_v));
	endtask

	// Reads all six registers back and compares with the tracker's copy.
	task automatic check_registers();
		reg_idx_t          idx;
		logic [APB_DW-1:0] want;
		for (int i = 0; i < 6; i++) begin
			idx = reg_idx_t'(i);
			case (idx)
				REG_PRESENT: want = 64'(board.present_keys);
				REG_REPEAT:  want = 64'(board.repeat_keys);
				REG_HOLD:    want = 64'(board.hold_ms);
				REG_LONG:    want = 64'(board.long_ms);
				REG_FIRST:   want = 64'(board.first_pause);
				default:     want = 64'(board.min_pause);
			endcase
			@(negedge clk);
			psel    = 1'b1;
			penable = 1'b0;
			pwrite  = 1'b0;
			paddr   = {idx, 3'b000};
			@(negedge clk);
			penable = 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== want) begin
				$error("%s readback mismatch: expected %0h, actual %0h", idx.name(), want, prdata);
				board.mismatches++;
			end
			@(negedge clk);
			psel    = 1'b0;
			penable = 1'b0;
		end
	endtask

	// Sends one scan item. Items come in bursts; between bursts the sender
	// either goes straight on, pauses briefly or pauses for longer.
	task automatic drive_scan(input logic [TIME_W-1:0] now, input logic [MASK_W-1:0] keys);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1:       gap = $urandom_range(40, 80);
				default: gap = $urandom_range(1, 10);
			endcase
			if (gap > 0) begin
				@(negedge clk);
				scan_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		scan_ch.valid        = 1'b1;
		scan_ch.time_ms      = now;
		scan_ch.pressed_mask = keys;
		do @(posedge clk); while (!scan_ch.ready);
		board.note_scan(now, keys);
	endtask

	// Drops valid and waits until every owed event is out and any silent
	// scan still being walked has finished.
	task automatic wait_idle();
		@(negedge clk);
		scan_ch.valid = 1'b0;
		burst_left    = 0;
		while (board.due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		logic [TIME_W-1:0] now;
		logic [MASK_W-1:0] keys;
		logic [MASK_W-1:0] present;
		wait_idle();
		present = rand48() | rand48();
		if ($urandom_range(0, 3) == 0)
			present = '1;
		apb_write({REG_PRESENT, 3'b000}, 64'(present));
		apb_write({REG_REPEAT, 3'b000}, 64'(rand48()));
		set_timing(pick_ms(0, 60), pick_ms(0, 400), pick_ms(1, 120), pick_ms(1, 40));
		check_registers();
		// about one phase in four starts just short of the time wrap
		if ($urandom_range(0, 3) == 0)
			now = 32'hFFFF_FFFF - $urandom_range(0, 400);
		else
			now = $urandom();
		keys = '0;
		repeat (count) begin
			// mostly a few keys change per scan; now and then noise or all/none
			case ($urandom_range(0, 15))
				0:       keys = rand48();
				1:       keys = '0;
				2:       keys = '1;
				default: keys ^= rand48() & rand48() & rand48() & rand48();
			endcase
			drive_scan(now, keys);
			case ($urandom_range(0, 15))
				0:       now = now;
				1:       now = now + $urandom_range(200, 2000);
				2:       now = now + $urandom();
				default: now = now + $urandom_range(1, 40);
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	localparam logic [TIME_W-1:0] T_WRAP = 32'hFFFF_FF00;
	localparam logic [TIME_W-1:0] T_ZERO = 32'h7FFF_FFFE;
	localparam logic [TIME_W-1:0] T_FULL = 32'h0000_1000;
	localparam logic [MASK_W-1:0] EVEN_COLS = 48'h5555_5555_5555;
	localparam logic [MASK_W-1:0] ODD_COLS  = 48'hAAAA_AAAA_AAAA;

	initial begin
		board                = new();
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		scan_ch.valid        = 1'b0;
		scan_ch.time_ms      = '0;
		scan_ch.pressed_mask = '0;
		evt_ch.ready         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values; no key present, so every pressed bit is ignored.
		check_registers();
		drive_scan(32'h0000_0000, '1);
		drive_scan(32'h0000_1234, '1);
		wait_idle();

		// Reset timing (hold 100, long 500, pause 100 down to 10), even
		// columns repeat. The sequence crosses the 2^32 wrap at +256.
		apb_write({REG_PRESENT, 3'b000}, 64'('1));
		apb_write({REG_REPEAT, 3'b000}, 64'(EVEN_COLS));
		check_registers();
		drive_scan(T_WRAP,       '1);       // all 48 keys pressed
		drive_scan(T_WRAP + 50,  '1);       // inside hold time: silent
		drive_scan(T_WRAP + 60,  '0);       // let go inside hold: still held
		drive_scan(T_WRAP + 150, '1);       // repeat timer arms, no event
		drive_scan(T_WRAP + 300, '1);       // first repeat, pause shrinks
		drive_scan(T_WRAP + 395, '1);       // just past the shrunk pause
		drive_scan(T_WRAP + 650, '1);       // long on odd columns, one repeat
		drive_scan(T_WRAP + 700, '0);       // releases, silent after long
		drive_scan(T_WRAP + 710, ODD_COLS); // fresh presses
		drive_scan(T_WRAP + 720, '0);       // inside hold: silent
		drive_scan(T_WRAP + 900, '0);       // releases
		wait_idle();

		// All timing at zero, including both pause registers; rows 0-3 repeat,
		// rows 4-5 go long. A write past the last register must be ignored.
		set_timing('0, '0, '0, '0);
		apb_write({REG_REPEAT, 3'b000}, 64'(48'h0000_FFFF_FFFF));
		apb_write(APB_AW'(6 * 8), '1);
		check_registers();
		drive_scan(T_ZERO,     '1);         // presses
		drive_scan(T_ZERO,     '1);         // same time: age not above zero
		drive_scan(T_ZERO + 1, '1);         // arms repeat, longs on rows 4-5
		drive_scan(T_ZERO + 2, '1);         // one repeat with zero pause
		drive_scan(T_ZERO + 3, '0);         // releases for repeat rows only
		wait_idle();

		// All timing at full scale; columns 0-3 repeat.
		set_timing('1, '1, '1, '1);
		apb_write({REG_REPEAT, 3'b000}, 64'(48'h0F0F_0F0F_0F0F));
		check_registers();
		drive_scan(T_FULL,                 '1);
		drive_scan(T_FULL + 65535,         '0);  // age equals hold: still held
		drive_scan(T_FULL + 65536,         '1);  // arms repeat, longs on cols 4-7
		drive_scan(T_FULL + 2 * 65536 + 1, '1);  // repeat, pause pinned at max
		drive_scan(T_FULL + 3 * 65536,     '0);  // releases on repeat columns
		wait_idle();

		repeat (4)
			random_phase(27);
		wait_idle();

		$display("Checked %0d scans and %0d events: %0d press, %0d repeat, %0d long, %0d release",
			board.scans, board.events, board.per_action[ACT_PRESS],
			board.per_action[ACT_REPEAT], board.per_action[ACT_LONG],
			board.per_action[ACT_RELEASE]);
		$display("Timing ran from all-zero to full scale, with scan times wrapping past 2^32");
		if (board.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
